/* hdl/crss_pkg.sv */
package crss_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int FRAC_BITS   = 4;
   localparam int SCALE_FRAC  = 8;

   localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W     = $clog2(STACK_DEPTH);
   localparam int CMD_W      = 4;
   localparam int COORD_W    = 20;
   localparam int EXT_W      = 19;
   localparam int WIDE_W     = COORD_W + 2;
   localparam int SC_W       = 18;
   localparam int ANS_W      = 16;
   localparam int NEST_W     = 8;
   localparam int SCREEN_W   = 14;
   localparam int SCALE_W    = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [SCREEN_W-1:0] SCREEN_W_RESET = SCREEN_W'(640);
   localparam logic [SCREEN_W-1:0] SCREEN_H_RESET = SCREEN_W'(480);
   localparam logic [SCALE_W-1:0]  SCALE_RESET    = SCALE_W'(256);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH          = 4'd0,
      CMD_POP           = 4'd1,
      CMD_CLEAR         = 4'd2,
      CMD_SUSPEND       = 4'd3,
      CMD_RESUME        = 4'd4,
      CMD_TEST_RECT     = 4'd5,
      CMD_TEST_POINT    = 4'd6,
      CMD_DEPTH         = 4'd7,
      CMD_UNDERFLOW     = 4'd8,
      CMD_CLR_UNDERFLOW = 4'd9
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_SCALE_X       = 2'd2,
      REG_SCALE_Y       = 2'd3
   } reg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [EXT_W-1:0]          w;
      logic [EXT_W-1:0]          h;
   } rect_type;

   typedef struct packed {
      logic                   start_ok;
      logic signed [SC_W-1:0] x;
      logic signed [SC_W-1:0] y;
      logic [SC_W-1:0]        w;
      logic [SC_W-1:0]        h;
   } scissor_type;

endpackage

/* hdl/crss_if.sv */
interface crss_req_if;
   logic                                valid;
   logic                                ready;
   logic [crss_pkg::CMD_W-1:0]          command;
   logic signed [crss_pkg::COORD_W-1:0] rect_x;
   logic signed [crss_pkg::COORD_W-1:0] rect_y;
   logic signed [crss_pkg::COORD_W-1:0] rect_w;
   logic signed [crss_pkg::COORD_W-1:0] rect_h;

   modport source (output valid, command, rect_x, rect_y, rect_w, rect_h, input ready);
   modport sink (input valid, command, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface crss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                scissor_changed;
   logic                                scissor_active;
   logic signed [crss_pkg::SC_W-1:0]    scissor_x;
   logic signed [crss_pkg::SC_W-1:0]    scissor_y;
   logic [crss_pkg::SC_W-1:0]           scissor_w;
   logic [crss_pkg::SC_W-1:0]           scissor_h;
   logic signed [crss_pkg::COORD_W-1:0] clip_x;
   logic signed [crss_pkg::COORD_W-1:0] clip_y;
   logic [crss_pkg::EXT_W-1:0]          clip_w;
   logic [crss_pkg::EXT_W-1:0]          clip_h;
   logic [crss_pkg::ANS_W-1:0]          answer;

   modport source (output valid, scissor_changed, scissor_active, scissor_x, scissor_y,
                   scissor_w, scissor_h, clip_x, clip_y, clip_w, clip_h, answer,
                   input ready);
   modport sink (input valid, scissor_changed, scissor_active, scissor_x, scissor_y,
                 scissor_w, scissor_h, clip_x, clip_y, clip_w, clip_h, answer,
                 output ready);
endinterface

/* hdl/crss_scissor.sv */
module crss_scissor (
   input  crss_pkg::rect_type              clip,
   input  logic [crss_pkg::SCREEN_W-1:0]   screen_w,
   input  logic [crss_pkg::SCREEN_W-1:0]   screen_h,
   input  logic [crss_pkg::SCALE_W-1:0]    scale_x,
   input  logic [crss_pkg::SCALE_W-1:0]    scale_y,
   output crss_pkg::scissor_type           result
);

   localparam int SH = crss_pkg::FRAC_BITS + crss_pkg::SCALE_FRAC;
   localparam int PW = crss_pkg::WIDE_W + crss_pkg::SCALE_W + 1;
   localparam logic signed [PW-1:0] CEIL_ADD = PW'((1 << SH) - 1);

   logic signed [crss_pkg::WIDE_W-1:0] near_x, near_y, far_x, far_y;
   logic signed [PW-1:0] sx, sy;
   logic signed [PW-1:0] p_near_x, p_near_y, p_far_x, p_far_y;
   logic signed [PW-1:0] x1, y1, x2, y2, dx, dy;

   always_comb begin
      near_x = crss_pkg::WIDE_W'(clip.x);
      near_y = crss_pkg::WIDE_W'(clip.y);
      far_x  = near_x + $signed(crss_pkg::WIDE_W'(clip.w));
      far_y  = near_y + $signed(crss_pkg::WIDE_W'(clip.h));
      sx     = $signed(PW'(scale_x));
      sy     = $signed(PW'(scale_y));

      p_near_x = PW'(near_x) * sx;
      p_near_y = PW'(near_y) * sy;
      p_far_x  = PW'(far_x) * sx;
      p_far_y  = PW'(far_y) * sy;

      // near edges floor, far edges ceil
      x1 = p_near_x >>> SH;
      y1 = p_near_y >>> SH;
      x2 = (p_far_x + CEIL_ADD) >>> SH;
      y2 = (p_far_y + CEIL_ADD) >>> SH;
      dx = x2 - x1;
      dy = y2 - y1;

      result.start_ok = (clip.w != '0) && (clip.h != '0) &&
                        (screen_w != '0) && (screen_h != '0) &&
                        !dx[PW-1] && (dx != '0) && !dy[PW-1] && (dy != '0);
      result.x = crss_pkg::SC_W'(x1);
      result.y = crss_pkg::SC_W'(y1);
      result.w = crss_pkg::SC_W'(dx);
      result.h = crss_pkg::SC_W'(dy);
   end

endmodule

/* hdl/clip_rect_stack_scissor_top.sv */
// a command beat is taken into the input register and executes from there against the
// stack top register and the entry below it, which a registered memory read keeps ready;
// its response is held in the result register; one command per cycle when not stalled
// reset: synchronous, active high; empties the stack, clears nesting, scissor and
// underflow count, and loads the screen size 640 x 480 and unity scales
module clip_rect_stack_scissor_top (
   input  logic                                clock,
   input  logic                                reset,
   crss_req_if.sink                            req_bus,
   crss_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [crss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crss_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = crss_pkg::COORD_W;
   localparam int WW = crss_pkg::WIDE_W;
   localparam int EW = crss_pkg::EXT_W;
   localparam int SW = crss_pkg::SC_W;

   // configuration
   logic [crss_pkg::SCREEN_W-1:0] screen_w_ff, screen_h_ff;
   logic [crss_pkg::SCALE_W-1:0]  scale_x_ff, scale_y_ff;

   // input register
   logic                    in_valid_ff;
   logic [crss_pkg::CMD_W-1:0] in_cmd_ff;
   logic signed [CW-1:0]    in_x_ff, in_y_ff, in_w_ff, in_h_ff;

   // state
   logic [crss_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [crss_pkg::NEST_W-1:0] nest_ff, nest_in;
   logic                        sc_on_ff, sc_on_in;
   logic signed [SW-1:0]        sc_x_ff, sc_x_in, sc_y_ff, sc_y_in;
   logic [SW-1:0]               sc_w_ff, sc_w_in, sc_h_ff, sc_h_in;
   logic [crss_pkg::ANS_W-1:0]  uf_ff, uf_in;
   crss_pkg::rect_type          top_ff, top_in;
   crss_pkg::rect_type          below_ff;
   crss_pkg::rect_type          stack_mem [crss_pkg::STACK_DEPTH];

   // result register
   logic                        rsp_valid_ff;
   logic                        rsp_changed_ff, rsp_active_ff;
   logic signed [SW-1:0]        rsp_sc_x_ff, rsp_sc_y_ff;
   logic [SW-1:0]               rsp_sc_w_ff, rsp_sc_h_ff;
   crss_pkg::rect_type          rsp_clip_ff;
   logic [crss_pkg::ANS_W-1:0]  rsp_answer_ff;

   logic exec;
   crss_pkg::rect_type screen_rect, cur, next_clip, isect, apply_rect;
   crss_pkg::scissor_type sres;
   logic signed [WW-1:0] bx, by, br, bb, cx, cy, cr, cb, l, t, r, b;
   logic mem_we, do_end, do_apply, changed;
   logic [crss_pkg::ANS_W-1:0] answer;
   logic [crss_pkg::CNT_W-1:0] count_eff;
   logic [crss_pkg::ADDR_W-1:0] rd_addr;

   assign exec          = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !reset && (!in_valid_ff || exec);

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff <= crss_pkg::SCREEN_W_RESET;
         screen_h_ff <= crss_pkg::SCREEN_H_RESET;
         scale_x_ff  <= crss_pkg::SCALE_RESET;
         scale_y_ff  <= crss_pkg::SCALE_RESET;
      end else if (csr_we) begin
         unique case (crss_pkg::reg_type'(csr_index))
            crss_pkg::REG_SCREEN_WIDTH:  screen_w_ff <= csr_wdata;
            crss_pkg::REG_SCREEN_HEIGHT: screen_h_ff <= csr_wdata;
            crss_pkg::REG_SCALE_X:       scale_x_ff <= crss_pkg::SCALE_W'(csr_wdata);
            crss_pkg::REG_SCALE_Y:       scale_y_ff <= crss_pkg::SCALE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_cmd_ff <= req_bus.command;
         in_x_ff   <= req_bus.rect_x;
         in_y_ff   <= req_bus.rect_y;
         in_w_ff   <= req_bus.rect_w;
         in_h_ff   <= req_bus.rect_h;
      end
   end

   always_comb begin
      screen_rect.x = '0;
      screen_rect.y = '0;
      screen_rect.w = EW'(screen_w_ff) << crss_pkg::FRAC_BITS;
      screen_rect.h = EW'(screen_h_ff) << crss_pkg::FRAC_BITS;
      cur = (count_ff != '0) ? top_ff : screen_rect;

      bx = WW'(in_x_ff);
      by = WW'(in_y_ff);
      br = bx + WW'(in_w_ff);
      bb = by + WW'(in_h_ff);
      cx = WW'(cur.x);
      cy = WW'(cur.y);
      cr = cx + $signed(WW'(cur.w));
      cb = cy + $signed(WW'(cur.h));

      l = (cx > bx) ? cx : bx;
      t = (cy > by) ? cy : by;
      r = (cr < br) ? cr : br;
      b = (cb < bb) ? cb : bb;
      if (r <= l || b <= t) begin
         isect = '0;
      end else begin
         isect.x = CW'(l);
         isect.y = CW'(t);
         isect.w = EW'(r - l);
         isect.h = EW'(b - t);
      end
   end

   always_comb begin
      count_in = count_ff;
      nest_in  = nest_ff;
      uf_in    = uf_ff;
      top_in   = top_ff;
      mem_we   = 1'b0;
      do_end   = 1'b0;
      do_apply = 1'b0;
      answer   = '0;
      apply_rect = top_ff;
      unique case (in_cmd_ff)
         crss_pkg::CMD_PUSH: begin
            if (count_ff >= crss_pkg::CNT_W'(crss_pkg::STACK_DEPTH)) begin
               answer = crss_pkg::ANS_W'(1);
            end else begin
               mem_we     = 1'b1;
               count_in   = count_ff + 1'b1;
               top_in     = isect;
               apply_rect = isect;
               do_apply   = 1'b1;
            end
         end
         crss_pkg::CMD_POP: begin
            if (count_ff == '0) begin
               if (uf_ff != '1) uf_in = uf_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               if (count_ff == crss_pkg::CNT_W'(1)) begin
                  do_end = (nest_ff == '0);
               end else begin
                  top_in     = below_ff;
                  apply_rect = below_ff;
                  do_apply   = 1'b1;
               end
            end
         end
         crss_pkg::CMD_CLEAR: begin
            count_in = '0;
            do_end   = (nest_ff == '0);
         end
         crss_pkg::CMD_SUSPEND: begin
            if (nest_ff != '1) nest_in = nest_ff + 1'b1;
            do_end = 1'b1;
         end
         crss_pkg::CMD_RESUME: begin
            if (nest_ff != '0) begin
               nest_in  = nest_ff - 1'b1;
               do_apply = (nest_ff == crss_pkg::NEST_W'(1)) && (count_ff != '0);
            end
         end
         crss_pkg::CMD_TEST_RECT: begin
            answer = crss_pkg::ANS_W'(bx < cr && br > cx && by < cb && bb > cy);
         end
         crss_pkg::CMD_TEST_POINT: begin
            answer = crss_pkg::ANS_W'(bx >= cx && bx < cr && by >= cy && by < cb);
         end
         crss_pkg::CMD_DEPTH:         answer = crss_pkg::ANS_W'(count_ff);
         crss_pkg::CMD_UNDERFLOW:     answer = uf_ff;
         crss_pkg::CMD_CLR_UNDERFLOW: uf_in = '0;
         default: ;
      endcase
   end

   crss_scissor u_scissor (
      .clip     (apply_rect),
      .screen_w (screen_w_ff),
      .screen_h (screen_h_ff),
      .scale_x  (scale_x_ff),
      .scale_y  (scale_y_ff),
      .result   (sres)
   );

   always_comb begin
      changed  = 1'b0;
      sc_on_in = sc_on_ff;
      sc_x_in  = sc_x_ff;
      sc_y_in  = sc_y_ff;
      sc_w_in  = sc_w_ff;
      sc_h_in  = sc_h_ff;
      if (do_end && sc_on_ff) begin
         changed  = 1'b1;
         sc_on_in = 1'b0;
         sc_x_in  = '0;
         sc_y_in  = '0;
         sc_w_in  = '0;
         sc_h_in  = '0;
      end
      // nothing moves while suspended
      if (do_apply && nest_in == '0) begin
         changed  = sc_on_ff || sres.start_ok;
         sc_on_in = sres.start_ok;
         sc_x_in  = sres.start_ok ? sres.x : '0;
         sc_y_in  = sres.start_ok ? sres.y : '0;
         sc_w_in  = sres.start_ok ? sres.w : '0;
         sc_h_in  = sres.start_ok ? sres.h : '0;
      end
      next_clip = (count_in != '0) ? top_in : screen_rect;
      count_eff = exec ? count_in : count_ff;
      // entry below the top of the next cycle's stack
      rd_addr   = crss_pkg::ADDR_W'(count_eff - crss_pkg::CNT_W'(2));
   end

   always_ff @(posedge clock) begin
      if (exec && mem_we) begin
         stack_mem[count_ff[crss_pkg::ADDR_W-1:0]] <= isect;
      end
      below_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         nest_ff  <= '0;
         sc_on_ff <= 1'b0;
         sc_x_ff  <= '0;
         sc_y_ff  <= '0;
         sc_w_ff  <= '0;
         sc_h_ff  <= '0;
         uf_ff    <= '0;
      end else if (exec) begin
         count_ff <= count_in;
         nest_ff  <= nest_in;
         sc_on_ff <= sc_on_in;
         sc_x_ff  <= sc_x_in;
         sc_y_ff  <= sc_y_in;
         sc_w_ff  <= sc_w_in;
         sc_h_ff  <= sc_h_in;
         uf_ff    <= uf_in;
      end
      if (exec) begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (exec) begin
         rsp_changed_ff <= changed;
         rsp_active_ff  <= sc_on_in;
         rsp_sc_x_ff    <= sc_x_in;
         rsp_sc_y_ff    <= sc_y_in;
         rsp_sc_w_ff    <= sc_w_in;
         rsp_sc_h_ff    <= sc_h_in;
         rsp_clip_ff    <= next_clip;
         rsp_answer_ff  <= answer;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.scissor_changed = rsp_changed_ff;
   assign rsp_bus.scissor_active  = rsp_active_ff;
   assign rsp_bus.scissor_x       = rsp_sc_x_ff;
   assign rsp_bus.scissor_y       = rsp_sc_y_ff;
   assign rsp_bus.scissor_w       = rsp_sc_w_ff;
   assign rsp_bus.scissor_h       = rsp_sc_h_ff;
   assign rsp_bus.clip_x          = rsp_clip_ff.x;
   assign rsp_bus.clip_y          = rsp_clip_ff.y;
   assign rsp_bus.clip_w          = rsp_clip_ff.w;
   assign rsp_bus.clip_h          = rsp_clip_ff.h;
   assign rsp_bus.answer          = rsp_answer_ff;

endmodule

/* hdl/crss_checker.sv */
module crss_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              scissor_active,
   input logic signed [crss_pkg::SC_W-1:0]  scissor_x,
   input logic signed [crss_pkg::SC_W-1:0]  scissor_y,
   input logic [crss_pkg::SC_W-1:0]         scissor_w,
   input logic [crss_pkg::SC_W-1:0]         scissor_h,
   input logic [crss_pkg::ANS_W-1:0]        answer
);

   // stalled response beat holds its answer and scissor width
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(answer) && $stable(scissor_w))
      else $error("response beat changed while stalled");

   // scissor rectangle reads zero while the scissor is off
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !scissor_active |->
         scissor_x == '0 && scissor_y == '0 && scissor_w == '0 && scissor_h == '0)
      else $error("inactive scissor with nonzero rectangle");

   // an active scissor is never empty
   a_on_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && scissor_active |-> scissor_w != '0 && scissor_h != '0)
      else $error("active scissor with empty size");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind clip_rect_stack_scissor_top crss_checker u_crss_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .scissor_active (rsp_bus.scissor_active),
   .scissor_x      (rsp_bus.scissor_x),
   .scissor_y      (rsp_bus.scissor_y),
   .scissor_w      (rsp_bus.scissor_w),
   .scissor_h      (rsp_bus.scissor_h),
   .answer         (rsp_bus.answer)
);

/* dv/testbench.sv */
module testbench;

   localparam logic [crss_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 4'd10;
   localparam logic [crss_pkg::CMD_W-1:0] CMD_LAST_UNUSED  = 4'd15;
   localparam int SCALED_SHIFT   = crss_pkg::FRAC_BITS + crss_pkg::SCALE_FRAC;
   localparam int UNDERFLOW_MAX  = 65535;
   localparam int NEST_MAX       = 255;
   localparam int UNDERFLOW_POPS = 4;
   localparam int DIRECTED_ROWS  = 25;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_COMMANDS = 57;

   typedef struct packed {
      logic                                changed;
      logic                                active;
      logic signed [crss_pkg::SC_W-1:0]    sc_x;
      logic signed [crss_pkg::SC_W-1:0]    sc_y;
      logic [crss_pkg::SC_W-1:0]           sc_w;
      logic [crss_pkg::SC_W-1:0]           sc_h;
      logic signed [crss_pkg::COORD_W-1:0] clip_x;
      logic signed [crss_pkg::COORD_W-1:0] clip_y;
      logic [crss_pkg::EXT_W-1:0]          clip_w;
      logic [crss_pkg::EXT_W-1:0]          clip_h;
      logic [crss_pkg::ANS_W-1:0]          answer;
   } clip_status_type;

   typedef struct packed {
      logic [crss_pkg::CMD_W-1:0]          command;
      logic signed [crss_pkg::COORD_W-1:0] x;
      logic signed [crss_pkg::COORD_W-1:0] y;
      logic signed [crss_pkg::COORD_W-1:0] w;
      logic signed [crss_pkg::COORD_W-1:0] h;
      logic                                typed;
      clip_status_type                     status;
   } stim_row_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [crss_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [crss_pkg::CSR_DATA_W-1:0] csr_wdata;

   crss_req_if req_bus ();
   crss_rsp_if rsp_bus ();

   clip_rect_stack_scissor_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // screen at reset is 640 x 480 pixels, 10240 x 7680 in fixed point
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{crss_pkg::CMD_DEPTH, 0, 0, 0, 0, 1'b1,
        '{1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 10240, 7680, 0}},
      '{crss_pkg::CMD_POP, 0, 0, 0, 0, 1'b1,
        '{1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 10240, 7680, 0}},
      '{crss_pkg::CMD_UNDERFLOW, 0, 0, 0, 0, 1'b1,
        '{1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 10240, 7680, 1}},
      '{crss_pkg::CMD_CLR_UNDERFLOW, 5, 5, 5, 5, 1'b0, '0},
      '{crss_pkg::CMD_PUSH, 0, 0, 10240, 7680, 1'b1,
        '{1'b1, 1'b1, 0, 0, 640, 480, 0, 0, 10240, 7680, 0}},
      '{crss_pkg::CMD_PUSH, -524288, -524288, 524287, 524287, 1'b1,
        '{1'b1, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{crss_pkg::CMD_TEST_POINT, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_TEST_RECT, -524288, -524288, 524287, 524287, 1'b0, '0},
      '{crss_pkg::CMD_POP, 0, 0, 0, 0, 1'b1,
        '{1'b1, 1'b1, 0, 0, 640, 480, 0, 0, 10240, 7680, 0}},
      '{crss_pkg::CMD_PUSH, 524287, 524287, 524287, 524287, 1'b0, '0},
      '{crss_pkg::CMD_POP, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_PUSH, 24, 40, 1000, 3000, 1'b0, '0},
      '{crss_pkg::CMD_SUSPEND, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_SUSPEND, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_PUSH, -80, -80, 200, 200, 1'b0, '0},
      '{crss_pkg::CMD_RESUME, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_RESUME, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_RESUME, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_TEST_RECT, 100, 100, 16, 16, 1'b0, '0},
      '{crss_pkg::CMD_TEST_POINT, 119, 119, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_TEST_POINT, 120, 120, 0, 0, 1'b0, '0},
      '{CMD_LAST_UNUSED, -1, -1, -1, -1, 1'b0, '0},
      '{crss_pkg::CMD_DEPTH, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0, '0},
      '{crss_pkg::CMD_PUSH, 0, 0, -524288, -524288, 1'b0, '0}
   };

   int cfg_sets [RANDOM_PHASES][4] = '{
      '{640, 480, 256, 256},
      '{16383, 16383, 1023, 1023},
      '{0, 0, 0, 0},
      '{320, 200, 512, 384},
      '{1, 16383, 1023, 1},
      '{0, 0, 0, 0},
      '{1024, 768, 128, 300}
   };

   // mirrored block state
   longint clip_l [crss_pkg::STACK_DEPTH];
   longint clip_t [crss_pkg::STACK_DEPTH];
   longint clip_wd [crss_pkg::STACK_DEPTH];
   longint clip_ht [crss_pkg::STACK_DEPTH];
   int     held_depth = 0;
   int     held_nest = 0;
   int     held_underflow = 0;
   bit     sci_on = 1'b0;
   longint sci_x = 0, sci_y = 0, sci_w = 0, sci_h = 0;
   int     cfg_screen_w = 640;
   int     cfg_screen_h = 480;
   int     cfg_scale_x = 256;
   int     cfg_scale_y = 256;

   clip_status_type pending_status [$];
   int              mismatch_count = 0;
   int              send_gap_pct = 0;
   int              stall_pct = 0;

   function automatic logic signed [crss_pkg::COORD_W-1:0] rand_coord();
      return crss_pkg::COORD_W'($urandom);
   endfunction

   function automatic void top_clip(output longint x, y, w, h);
      if (held_depth > 0) begin
         x = clip_l[held_depth-1];
         y = clip_t[held_depth-1];
         w = clip_wd[held_depth-1];
         h = clip_ht[held_depth-1];
      end else begin
         x = 0;
         y = 0;
         w = longint'(cfg_screen_w) << crss_pkg::FRAC_BITS;
         h = longint'(cfg_screen_h) << crss_pkg::FRAC_BITS;
      end
   endfunction

   function automatic bit drop_scissor();
      bit was_on;
      was_on = sci_on;
      sci_on = 1'b0;
      sci_x = 0;
      sci_y = 0;
      sci_w = 0;
      sci_h = 0;
      return was_on;
   endfunction

   function automatic bit place_scissor(longint l, t, w, h);
      longint x1, y1, x2, y2;
      bit chg;
      if (held_nest != 0) return 1'b0;
      chg = drop_scissor();
      if (w <= 0 || h <= 0 || cfg_screen_w == 0 || cfg_screen_h == 0) return chg;
      // arithmetic shift floors; ceil is the negated floor of the negation
      x1 = (l * cfg_scale_x) >>> SCALED_SHIFT;
      y1 = (t * cfg_scale_y) >>> SCALED_SHIFT;
      x2 = -((-(l + w) * cfg_scale_x) >>> SCALED_SHIFT);
      y2 = -((-(t + h) * cfg_scale_y) >>> SCALED_SHIFT);
      if (x2 - x1 <= 0 || y2 - y1 <= 0) return chg;
      sci_on = 1'b1;
      sci_x = x1;
      sci_y = y1;
      sci_w = x2 - x1;
      sci_h = y2 - y1;
      return 1'b1;
   endfunction

   function automatic clip_status_type step_clip_stack(logic [crss_pkg::CMD_W-1:0] cmd,
                                                       longint bx, by, bw, bh);
      longint cx, cy, cw, ch, l, t, r, b;
      bit chg;
      logic [crss_pkg::ANS_W-1:0] ans;
      clip_status_type s;
      chg = 1'b0;
      ans = '0;
      top_clip(cx, cy, cw, ch);
      case (cmd)
         crss_pkg::CMD_PUSH: begin
            if (held_depth >= crss_pkg::STACK_DEPTH) begin
               ans = crss_pkg::ANS_W'(1);
            end else begin
               l = (cx > bx) ? cx : bx;
               t = (cy > by) ? cy : by;
               r = (cx + cw < bx + bw) ? cx + cw : bx + bw;
               b = (cy + ch < by + bh) ? cy + ch : by + bh;
               if (r <= l || b <= t) begin
                  l = 0;
                  t = 0;
                  r = 0;
                  b = 0;
               end
               clip_l[held_depth] = l;
               clip_t[held_depth] = t;
               clip_wd[held_depth] = r - l;
               clip_ht[held_depth] = b - t;
               held_depth++;
               chg = place_scissor(l, t, r - l, b - t);
            end
         end
         crss_pkg::CMD_POP: begin
            if (held_depth == 0) begin
               if (held_underflow < UNDERFLOW_MAX) held_underflow++;
            end else begin
               held_depth--;
               if (held_depth == 0) begin
                  if (held_nest == 0) chg = drop_scissor();
               end else begin
                  chg = place_scissor(clip_l[held_depth-1], clip_t[held_depth-1],
                                      clip_wd[held_depth-1], clip_ht[held_depth-1]);
               end
            end
         end
         crss_pkg::CMD_CLEAR: begin
            held_depth = 0;
            if (held_nest == 0) chg = drop_scissor();
         end
         crss_pkg::CMD_SUSPEND: begin
            if (held_nest < NEST_MAX) held_nest++;
            chg = drop_scissor();
         end
         crss_pkg::CMD_RESUME: begin
            if (held_nest > 0) begin
               held_nest--;
               if (held_nest == 0 && held_depth > 0) begin
                  chg = place_scissor(clip_l[held_depth-1], clip_t[held_depth-1],
                                      clip_wd[held_depth-1], clip_ht[held_depth-1]);
               end
            end
         end
         crss_pkg::CMD_TEST_RECT:
            ans = crss_pkg::ANS_W'(bx < cx + cw && bx + bw > cx &&
                                   by < cy + ch && by + bh > cy);
         crss_pkg::CMD_TEST_POINT:
            ans = crss_pkg::ANS_W'(bx >= cx && bx < cx + cw &&
                                   by >= cy && by < cy + ch);
         crss_pkg::CMD_DEPTH: ans = crss_pkg::ANS_W'(held_depth);
         crss_pkg::CMD_UNDERFLOW: ans = crss_pkg::ANS_W'(held_underflow);
         crss_pkg::CMD_CLR_UNDERFLOW: held_underflow = 0;
         default: ;
      endcase
      top_clip(cx, cy, cw, ch);
      s.changed = chg;
      s.active = sci_on;
      s.sc_x = sci_x[crss_pkg::SC_W-1:0];
      s.sc_y = sci_y[crss_pkg::SC_W-1:0];
      s.sc_w = sci_w[crss_pkg::SC_W-1:0];
      s.sc_h = sci_h[crss_pkg::SC_W-1:0];
      s.clip_x = cx[crss_pkg::COORD_W-1:0];
      s.clip_y = cy[crss_pkg::COORD_W-1:0];
      s.clip_w = cw[crss_pkg::EXT_W-1:0];
      s.clip_h = ch[crss_pkg::EXT_W-1:0];
      s.answer = ans;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic signed [63:0] got, want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   task automatic check_field(string what, logic signed [63:0] got, want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic send_command(input logic [crss_pkg::CMD_W-1:0] cmd,
                               input logic signed [crss_pkg::COORD_W-1:0] x, y, w, h,
                               input logic typed, input clip_status_type fixed);
      clip_status_type want;
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.rect_x <= x;
      req_bus.rect_y <= y;
      req_bus.rect_w <= w;
      req_bus.rect_h <= h;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = step_clip_stack(cmd, x, y, w, h);
      if (typed) want = fixed;
      pending_status = {pending_status, want};
   endtask

   task automatic send_random_command();
      longint cx, cy, cw, ch;
      logic signed [crss_pkg::COORD_W-1:0] x, y, w, h;
      logic [crss_pkg::CMD_W-1:0] cmd;
      int pick;
      top_clip(cx, cy, cw, ch);
      pick = $urandom_range(99);
      if (pick < 30) cmd = crss_pkg::CMD_PUSH;
      else if (pick < 48) cmd = crss_pkg::CMD_POP;
      else if (pick < 52) cmd = crss_pkg::CMD_CLEAR;
      else if (pick < 58) cmd = crss_pkg::CMD_SUSPEND;
      else if (pick < 66) cmd = crss_pkg::CMD_RESUME;
      else if (pick < 74) cmd = crss_pkg::CMD_TEST_RECT;
      else if (pick < 84) cmd = crss_pkg::CMD_TEST_POINT;
      else if (pick < 88) cmd = crss_pkg::CMD_DEPTH;
      else if (pick < 92) cmd = crss_pkg::CMD_UNDERFLOW;
      else if (pick < 95) cmd = crss_pkg::CMD_CLR_UNDERFLOW;
      else cmd = crss_pkg::CMD_W'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
      if ($urandom_range(9) < 8) begin
         // mostly rectangles around the current clip so nesting goes deep
         x = crss_pkg::COORD_W'(cx - 16 + longint'($urandom_range(int'(cw) + 32)));
         y = crss_pkg::COORD_W'(cy - 16 + longint'($urandom_range(int'(ch) + 32)));
         w = crss_pkg::COORD_W'(longint'($urandom_range(int'(cw) + 32)) - 8);
         h = crss_pkg::COORD_W'(longint'($urandom_range(int'(ch) + 32)) - 8);
      end else begin
         x = rand_coord();
         y = rand_coord();
         w = rand_coord();
         h = rand_coord();
      end
      send_command(cmd, x, y, w, h, 1'b0, '0);
   endtask

   task automatic write_registers(input int width_px, height_px, sx, sy);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= crss_pkg::REG_SCREEN_WIDTH;
      csr_wdata <= crss_pkg::CSR_DATA_W'(width_px);
      @(posedge clock);
      csr_index <= crss_pkg::REG_SCREEN_HEIGHT;
      csr_wdata <= crss_pkg::CSR_DATA_W'(height_px);
      @(posedge clock);
      csr_index <= crss_pkg::REG_SCALE_X;
      csr_wdata <= crss_pkg::CSR_DATA_W'(sx);
      @(posedge clock);
      csr_index <= crss_pkg::REG_SCALE_Y;
      csr_wdata <= crss_pkg::CSR_DATA_W'(sy);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_screen_w = width_px & 16'h3FFF;
      cfg_screen_h = height_px & 16'h3FFF;
      cfg_scale_x = sx & 16'h3FF;
      cfg_scale_y = sy & 16'h3FF;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      clip_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("unexpected response beat", 1, 0);
         end else begin
            want = pending_status.pop_front();
            check_field("scissor_changed", rsp_bus.scissor_changed, want.changed);
            check_field("scissor_active", rsp_bus.scissor_active, want.active);
            check_field("scissor_x", rsp_bus.scissor_x, want.sc_x);
            check_field("scissor_y", rsp_bus.scissor_y, want.sc_y);
            check_field("scissor_w", rsp_bus.scissor_w, want.sc_w);
            check_field("scissor_h", rsp_bus.scissor_h, want.sc_h);
            check_field("clip_x", rsp_bus.clip_x, want.clip_x);
            check_field("clip_y", rsp_bus.clip_y, want.clip_y);
            check_field("clip_w", rsp_bus.clip_w, want.clip_w);
            check_field("clip_h", rsp_bus.clip_h, want.clip_h);
            check_field("answer", rsp_bus.answer, want.answer);
         end
      end
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.command <= crss_pkg::CMD_PUSH;
      req_bus.rect_x <= '0;
      req_bus.rect_y <= '0;
      req_bus.rect_w <= '0;
      req_bus.rect_h <= '0;
      csr_we <= 1'b0;
      csr_index <= crss_pkg::REG_SCREEN_WIDTH;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_command(directed_rows[i].command, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].w, directed_rows[i].h, directed_rows[i].typed,
                      directed_rows[i].status);
      end

      // saturate the suspend nesting, then a few underflows
      send_command(crss_pkg::CMD_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), 1'b0, '0);
      send_command(crss_pkg::CMD_PUSH, 160, 160, 4000, 2000, 1'b0, '0);
      for (int i = 0; i < NEST_MAX + 2; i++)
         send_command(crss_pkg::CMD_SUSPEND, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), 1'b0, '0);
      send_command(crss_pkg::CMD_PUSH, 320, 320, 800, 800, 1'b0, '0);
      for (int i = 0; i < NEST_MAX + 2; i++)
         send_command(crss_pkg::CMD_RESUME, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), 1'b0, '0);
      send_command(crss_pkg::CMD_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), 1'b0, '0);
      for (int i = 0; i < UNDERFLOW_POPS; i++)
         send_command(crss_pkg::CMD_POP, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), 1'b0, '0);
      send_command(crss_pkg::CMD_UNDERFLOW, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), 1'b0, '0);
      send_command(crss_pkg::CMD_CLR_UNDERFLOW, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), 1'b0, '0);
      send_command(crss_pkg::CMD_UNDERFLOW, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), 1'b0, '0);
      req_bus.valid <= 1'b0;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 5) begin
            write_registers($urandom_range(16383), $urandom_range(16383),
                            $urandom_range(1023), $urandom_range(1023));
         end else begin
            write_registers(cfg_sets[p][0], cfg_sets[p][1], cfg_sets[p][2], cfg_sets[p][3]);
         end
         case (p % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 56; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 56; end
            default: begin send_gap_pct = 27; stall_pct = 27; end
         endcase
         for (int i = 0; i < PHASE_COMMANDS; i++) send_random_command();
         req_bus.valid <= 1'b0;
      end

      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* clip_rect_stack_scissor_top.f */
hdl/crss_pkg.sv
hdl/crss_if.sv
hdl/crss_scissor.sv
hdl/clip_rect_stack_scissor_top.sv
hdl/crss_checker.sv
dv/testbench.sv
